// ----- hdl/fwam_pkg.sv -----
// Shared types and constants for the field/wall angle and Mach metrics block.
`timescale 1ns / 1ps
package fwam_pkg;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam logic [22:0] ANGLE_MAX    = 23'd5898240;
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

  localparam logic [26:0] ATAN_Q20 [CORDIC_STEPS] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058, 27'd1876857,
    27'd938658, 27'd469357, 27'd234682, 27'd117342, 27'd58671, 27'd29335,
    27'd14668, 27'd7334, 27'd3667, 27'd1833, 27'd917, 27'd458,
    27'd229, 27'd115, 27'd57, 27'd29, 27'd14, 27'd7
  };

  typedef struct packed {
    logic signed [31:0] flow_speed;
    logic        [30:0] sound_speed;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } in_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [31:0] cosine;
    logic        [22:0] angle_deg;
    logic        [31:0] mach_parallel;
    logic        [31:0] normal_speed;
    logic        [31:0] mach_normal;
  } out_t;

endpackage

// ----- hdl/fwam_if.sv -----
// Request and result channel interfaces with valid/ready handshake.
`timescale 1ns / 1ps
interface fwam_in_if;
  logic           valid;
  logic           ready;
  fwam_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fwam_out_if;
  logic           valid;
  logic           ready;
  fwam_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/field_wall_angle_mach_metrics.sv -----
// Top level: pipelined field/wall angle, cosine and Mach metrics.
// Throughput: one request per cycle while the result is not stalled;
// a bit-per-stage square root, divider and CORDIC chain sets the depth,
// and the whole pipe advances together.
// A stalled result freezes every stage; nothing is lost or repeated.
// Reset clears the stage valid bits only; data registers are not reset.
`timescale 1ns / 1ps
module field_wall_angle_mach_metrics (
  input  logic              clk_i,
  input  logic              rst_ni,
  fwam_in_if.sink           in_i,
  fwam_out_if.source        out_o
);

  localparam int S_LZ   = 1;
  localparam int S_SHF  = 2;
  localparam int MP0    = 2;
  localparam int S_MUL  = 3;
  localparam int S_SUM  = 4;
  localparam int S_DOT  = 5;
  localparam int SQ0    = 6;
  localparam int S_DEN  = SQ0 + 31;
  localparam int S_AINI = S_DEN + 1;
  localparam int ADIV0  = S_AINI + 1;
  localparam int S_ASAT = ADIV0 + 31;
  localparam int S_AMUL = S_ASAT + 1;
  localparam int S_SINI = S_AMUL + 1;
  localparam int SQ1    = S_SINI + 1;
  localparam int MN0    = SQ1;
  localparam int C0     = MN0 + 32;
  localparam int S_FIN  = C0 + fwam_pkg::CORDIC_STEPS;
  localparam int NST    = S_FIN + 1;

  typedef struct packed {
    logic               ok;
    logic        [31:0] flow;
    logic        [30:0] cs;
    logic [2:0]  [31:0] bm;
    logic [2:0]  [31:0] nm;
    logic        [2:0]  bs;
    logic        [2:0]  ns;
    logic        [31:0] bmax;
    logic        [31:0] nmax;
    logic        [4:0]  bsh;
    logic        [4:0]  nsh;
    logic [2:0]  [59:0] pr;
    logic [2:0]  [59:0] b2;
    logic [2:0]  [59:0] n2;
    logic        [61:0] pos;
    logic        [61:0] neg;
    logic        [61:0] sqb;
    logic        [61:0] sqn;
    logic        [61:0] dotm;
    logic               dneg;
    logic        [63:0] rb;
    logic        [63:0] rn;
    logic        [31:0] qb;
    logic        [31:0] qn;
    logic        [61:0] mbmn;
    logic        [31:0] den;
    logic               aovf;
    logic        [63:0] arem;
    logic        [31:0] aq;
    logic        [30:0] a;
    logic        [61:0] a2;
    logic        [62:0] prod;
    logic        [63:0] rs;
    logic        [31:0] qs;
    logic               mpovf;
    logic        [63:0] mprem;
    logic        [31:0] mpq;
    logic               mnovf;
    logic        [63:0] mnrem;
    logic        [31:0] mnq;
    logic        [31:0] nspd;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [31:0] cz;
    fwam_pkg::out_t     res;
  } pipe_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] max3(input logic [31:0] x, input logic [31:0] y,
                                       input logic [31:0] z);
    logic [31:0] m;
    m = (x > y) ? x : y;
    max3 = (z > m) ? z : m;
  endfunction

  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    msb_pos = p;
  endfunction

  function automatic logic [31:0] scale(input logic [31:0] m, input logic [4:0] sh);
    logic [62:0] w;
    w = {m, 31'b0} >> ({1'b0, sh} + 6'd2);
    scale = {2'b0, w[29:0]};
  endfunction

  function automatic logic signed [35:0] shr_tz(input logic signed [35:0] v, input int s);
    logic [35:0] m;
    logic [35:0] r;
    m = v[35] ? 36'(-v) : 36'(v);
    r = m >> s;
    shr_tz = v[35] ? -$signed(r) : $signed(r);
  endfunction

  function automatic pipe_t front(input fwam_pkg::in_t d);
    pipe_t n;
    n       = '0;
    n.flow  = mag32(d.flow_speed);
    n.cs    = d.sound_speed;
    n.bm[0] = mag32(d.field_x);
    n.bm[1] = mag32(d.field_y);
    n.bm[2] = mag32(d.field_z);
    n.nm[0] = mag32(d.normal_x);
    n.nm[1] = mag32(d.normal_y);
    n.nm[2] = mag32(d.normal_z);
    n.bs    = {d.field_z[31], d.field_y[31], d.field_x[31]};
    n.ns    = {d.normal_z[31], d.normal_y[31], d.normal_x[31]};
    n.bmax  = max3(n.bm[0], n.bm[1], n.bm[2]);
    n.nmax  = max3(n.nm[0], n.nm[1], n.nm[2]);
    n.ok    = (d.sound_speed != '0) && (n.bmax != '0) && (n.nmax != '0);
    front   = n;
  endfunction

  function automatic pipe_t stage_fn(input int k, input pipe_t p);
    pipe_t       n;
    int          j;
    int          b;
    logic [63:0] t;
    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic signed [31:0] at;
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [31:0] z;
    logic [30:0] zz;
    logic [31:0] r;
    n = p;
    if (k == S_LZ) begin
      n.bsh   = msb_pos(p.bmax);
      n.nsh   = msb_pos(p.nmax);
      n.mpovf = {16'b0, p.flow} >= {1'b0, p.cs, 16'b0};
      n.mprem = {16'b0, p.flow, 16'b0};
      n.mpq   = '0;
    end
    if (k == S_SHF) begin
      for (int i = 0; i < 3; i++) begin
        n.bm[i] = scale(p.bm[i], p.bsh);
        n.nm[i] = scale(p.nm[i], p.nsh);
      end
    end
    if (k >= MP0 && k < MP0 + 32) begin
      j = 31 - (k - MP0);
      t = {33'b0, p.cs} << j;
      if (!p.mpovf && p.mprem >= t) begin
        n.mprem = p.mprem - t;
        n.mpq   = p.mpq | (32'd1 << j);
      end
    end
    if (k == S_MUL) begin
      for (int i = 0; i < 3; i++) begin
        n.pr[i] = p.bm[i][29:0] * p.nm[i][29:0];
        n.b2[i] = p.bm[i][29:0] * p.bm[i][29:0];
        n.n2[i] = p.nm[i][29:0] * p.nm[i][29:0];
      end
    end
    if (k == S_SUM) begin
      n.pos = '0;
      n.neg = '0;
      for (int i = 0; i < 3; i++) begin
        if (p.bs[i] != p.ns[i]) n.neg = n.neg + 62'(p.pr[i]);
        else n.pos = n.pos + 62'(p.pr[i]);
      end
      n.sqb = 62'(p.b2[0]) + 62'(p.b2[1]) + 62'(p.b2[2]);
      n.sqn = 62'(p.n2[0]) + 62'(p.n2[1]) + 62'(p.n2[2]);
    end
    if (k == S_DOT) begin
      n.dneg = p.neg > p.pos;
      n.dotm = n.dneg ? (p.neg - p.pos) : (p.pos - p.neg);
      n.rb   = {2'b0, p.sqb};
      n.rn   = {2'b0, p.sqn};
      n.qb   = '0;
      n.qn   = '0;
    end
    if (k >= SQ0 && k < SQ0 + 31) begin
      b = 30 - (k - SQ0);
      t = ({32'b0, p.qb} << (b + 1)) + (64'd1 << (2 * b));
      if (p.rb >= t) begin
        n.rb = p.rb - t;
        n.qb = p.qb | (32'd1 << b);
      end
      t = ({32'b0, p.qn} << (b + 1)) + (64'd1 << (2 * b));
      if (p.rn >= t) begin
        n.rn = p.rn - t;
        n.qn = p.qn | (32'd1 << b);
      end
    end
    if (k == S_DEN) begin
      n.mbmn = p.qb[30:0] * p.qn[30:0];
    end
    if (k == S_AINI) begin
      n.den  = p.mbmn[61:30];
      n.aovf = {2'b0, p.dotm} >= ({32'b0, n.den} << 31);
      n.arem = {2'b0, p.dotm};
      n.aq   = '0;
    end
    if (k >= ADIV0 && k < ADIV0 + 31) begin
      j = 30 - (k - ADIV0);
      t = {32'b0, p.den} << j;
      if (!p.aovf && p.arem >= t) begin
        n.arem = p.arem - t;
        n.aq   = p.aq | (32'd1 << j);
      end
    end
    if (k == S_ASAT) begin
      n.a = (p.aovf || p.aq > {1'b0, fwam_pkg::Q30_ONE}) ? fwam_pkg::Q30_ONE : p.aq[30:0];
    end
    if (k == S_AMUL) begin
      n.a2   = p.a * p.a;
      n.prod = p.flow * p.a;
    end
    if (k == S_SINI) begin
      n.rs    = (64'd1 << 60) - {2'b0, p.a2};
      n.qs    = '0;
      n.mnovf = {15'b0, p.prod[61:46]} >= p.cs;
      n.mnrem = {16'b0, p.prod[61:14]};
      n.mnq   = '0;
      t       = {1'b0, p.prod} + (64'd1 << 29);
      n.nspd  = t[61:30];
    end
    if (k >= SQ1 && k < SQ1 + 31) begin
      b = 30 - (k - SQ1);
      t = ({32'b0, p.qs} << (b + 1)) + (64'd1 << (2 * b));
      if (p.rs >= t) begin
        n.rs = p.rs - t;
        n.qs = p.qs | (32'd1 << b);
      end
    end
    if (k >= MN0 && k < MN0 + 32) begin
      j = 31 - (k - MN0);
      t = {33'b0, p.cs} << j;
      if (!p.mnovf && p.mnrem >= t) begin
        n.mnrem = p.mnrem - t;
        n.mnq   = p.mnq | (32'd1 << j);
      end
    end
    if (k >= C0 && k < C0 + 24) begin
      j = k - C0;
      if (j == 0) begin
        x = $signed({5'b0, p.a});
        y = $signed({4'b0, p.qs});
        z = '0;
      end else begin
        x = p.cx;
        y = p.cy;
        z = p.cz;
      end
      dx = shr_tz(y, j);
      dy = shr_tz(x, j);
      at = $signed({5'b0, fwam_pkg::ATAN_Q20[j]});
      if (!y[35]) begin
        n.cx = x + dx;
        n.cy = y - dy;
        n.cz = z + at;
      end else begin
        n.cx = x - dx;
        n.cy = y + dy;
        n.cz = z - at;
      end
    end
    if (k == S_FIN) begin
      zz = p.cz[31] ? '0 : p.cz[30:0];
      r  = ({1'b0, zz} + 32'd8) >> 4;
      n.res = '0;
      if (p.ok) begin
        n.res.valid_res     = 1'b1;
        n.res.cosine        = p.dneg ? -$signed({1'b0, p.a}) : $signed({1'b0, p.a});
        n.res.angle_deg     = (r > {9'b0, fwam_pkg::ANGLE_MAX}) ? fwam_pkg::ANGLE_MAX
                                                                : r[22:0];
        n.res.mach_parallel = p.mpovf ? '1 : p.mpq;
        n.res.normal_speed  = p.nspd;
        n.res.mach_normal   = p.mnovf ? '1 : p.mnq;
      end
    end
    stage_fn = n;
  endfunction

  pipe_t            pipe_d [NST];
  pipe_t            pipe_q [NST];
  logic [NST-1:0]   vld_q;
  logic             adv;

  assign adv        = !vld_q[NST-1] || out_o.ready;
  assign in_i.ready = adv;
  assign out_o.valid = vld_q[NST-1];
  assign out_o.data  = pipe_q[NST-1].res;

  always_comb begin
    pipe_d[0] = front(in_i.data);
  end

  for (genvar g = 1; g < NST; g++) begin : g_stage
    always_comb begin
      pipe_d[g] = stage_fn(g, pipe_q[g-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q <= pipe_d;
    end
  end

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.valid_res |->
      out_o.data.cosine == '0 && out_o.data.angle_deg == '0 &&
      out_o.data.mach_parallel == '0 && out_o.data.normal_speed == '0 &&
      out_o.data.mach_normal == '0)
    else $error("invalid result carries nonzero fields");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.data.angle_deg <= fwam_pkg::ANGLE_MAX)
    else $error("angle beyond ninety degrees");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.cosine <= 32'sd1073741824) &&
                    (out_o.data.cosine >= -32'sd1073741824))
    else $error("cosine beyond one");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!out_o.valid || out_o.ready))
    else $error("request ready does not follow pipe advance");

endmodule
